FILE: src/chp_pkg.sv
// Shared constants and types for the counter-hash seed position pipeline.
`default_nettype none
package chp_pkg;

   // Item field widths
   localparam int BATCH_W    = 32;
   localparam int INDEX_W    = 31;
   localparam int REQ_DATA_W = 64;

   localparam int COORD_WIDTH_DEFAULT = 32;

   // Hash word and fraction widths
   localparam int HASH_W = 64;
   localparam int HALF_W = 32;

   // Key multiplier 0x100000001b3 = 2^40 + 0x1b3
   localparam int               KEY_MUL_SHIFT = 40;
   localparam int               KEY_LO_W      = BATCH_W + 9;
   localparam logic [KEY_LO_W-1:0] KEY_MUL_LO  = KEY_LO_W'(9'h1b3);

   // Finalizer constants
   localparam logic [HASH_W-1:0] GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [HASH_W-1:0] MIX_M1 = 64'hbf58476d1ce4e5b9;
   localparam logic [HASH_W-1:0] MIX_M2 = 64'h94d049bb133111eb;

   // Pipeline depths of the sub-units
   localparam int MIX_STAGES   = 5;
   localparam int PLACE_STAGES = 4;

   // Lane offsets added to the base hash
   localparam int LANE_OFS_W = 2;

   // Configuration register map
   localparam int CSR_ADDR_W = 3;
   typedef enum logic [CSR_ADDR_W-1:0] {
      CFG_LOW_X  = 3'd0,
      CFG_LOW_Y  = 3'd1,
      CFG_LOW_Z  = 3'd2,
      CFG_HIGH_X = 3'd3,
      CFG_HIGH_Y = 3'd4,
      CFG_HIGH_Z = 3'd5
   } cfg_index_type;

endpackage
`default_nettype wire

FILE: src/chp_mix.sv
// Five-stage splitmix64 finalizer with a small constant offset on its input.
`default_nettype none
module chp_mix (
   input  wire logic                                  clock,
   input  wire logic [chp_pkg::MIX_STAGES-1:0]        en_i,
   input  wire logic [chp_pkg::HASH_W-1:0]            z_i,
   input  wire logic [chp_pkg::LANE_OFS_W-1:0]        offset_i,
   output logic      [chp_pkg::HASH_W-1:0]            h_o
);

   localparam int HW = chp_pkg::HASH_W;
   localparam int HF = chp_pkg::HALF_W;

   logic [HW-1:0] a_in, b_in, c_in;
   logic [HW-1:0] a_ff, b_ff, c_ff;
   logic [HW-1:0] p0a_ff, p0b_ff;
   logic [HF-1:0] p1a_ff, p2a_ff, p1b_ff, p2b_ff;

   // 64-bit product mod 2^64 = lo*lo + ((hi*lo + lo*hi) << 32)
   assign a_in = z_i + chp_pkg::GOLDEN + HW'(offset_i);
   assign b_in = p0a_ff + {p1a_ff + p2a_ff, {HF{1'b0}}};
   assign c_in = p0b_ff + {p1b_ff + p2b_ff, {HF{1'b0}}};

   always_ff @(posedge clock) begin
      if (en_i[0]) begin
         a_ff <= a_in ^ (a_in >> 30);
      end
      if (en_i[1]) begin
         p0a_ff <= HW'(a_ff[HF-1:0]) * HW'(chp_pkg::MIX_M1[HF-1:0]);
         p1a_ff <= a_ff[HW-1:HF] * chp_pkg::MIX_M1[HF-1:0];
         p2a_ff <= a_ff[HF-1:0] * chp_pkg::MIX_M1[HW-1:HF];
      end
      if (en_i[2]) begin
         b_ff <= b_in ^ (b_in >> 27);
      end
      if (en_i[3]) begin
         p0b_ff <= HW'(b_ff[HF-1:0]) * HW'(chp_pkg::MIX_M2[HF-1:0]);
         p1b_ff <= b_ff[HW-1:HF] * chp_pkg::MIX_M2[HF-1:0];
         p2b_ff <= b_ff[HF-1:0] * chp_pkg::MIX_M2[HW-1:HF];
      end
      if (en_i[4]) begin
         c_ff <= c_in ^ (c_in >> 31);
      end
   end

   assign h_o = c_ff;

endmodule
`default_nettype wire

FILE: src/chp_place.sv
// Four-stage placement of one coordinate: low + floor((high - low) * fraction).
`default_nettype none
module chp_place #(
   parameter int COORD_WIDTH = chp_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic [chp_pkg::PLACE_STAGES-1:0]      en_i,
   input  wire logic [COORD_WIDTH-1:0]                low_i,
   input  wire logic [COORD_WIDTH-1:0]                high_i,
   input  wire logic [chp_pkg::HASH_W-1:0]            h_i,
   output logic      [COORD_WIDTH-1:0]                pos_o
);

   localparam int CW = COORD_WIDTH;
   localparam int HW = chp_pkg::HASH_W;
   localparam int HF = chp_pkg::HALF_W;

   logic [CW:0]   diff_in, ndiff_in;
   logic [HW-1:0] mag64_in;
   logic [HW-1:0] q_in;

   logic [CW-1:0] mag_ff;
   logic [HF-1:0] frac_ff;
   logic          neg1_ff, neg2_ff, neg3_ff;
   logic [HW-1:0] hp_ff, lp_ff;
   logic [CW-1:0] q_ff;
   logic          inexact_ff;
   logic [CW-1:0] pos_ff;

   assign diff_in  = {high_i[CW-1], high_i} - {low_i[CW-1], low_i};
   assign ndiff_in = -diff_in;
   assign mag64_in = HW'(mag_ff);
   assign q_in     = hp_ff + (lp_ff >> HF);

   always_ff @(posedge clock) begin
      if (en_i[0]) begin
         neg1_ff <= diff_in[CW];
         mag_ff  <= diff_in[CW] ? ndiff_in[CW-1:0] : diff_in[CW-1:0];
         frac_ff <= h_i[HW-1:HF];
      end
      if (en_i[1]) begin
         neg2_ff <= neg1_ff;
         hp_ff   <= HW'(mag64_in[HW-1:HF]) * HW'(frac_ff);
         lp_ff   <= HW'(mag64_in[HF-1:0]) * HW'(frac_ff);
      end
      if (en_i[2]) begin
         neg3_ff    <= neg2_ff;
         q_ff       <= q_in[CW-1:0];
         inexact_ff <= |lp_ff[HF-1:0];
      end
      if (en_i[3]) begin
         // floor toward minus infinity when the span is negative
         pos_ff <= neg3_ff ? (low_i - q_ff - CW'(inexact_ff)) : (low_i + q_ff);
      end
   end

   assign pos_o = pos_ff;

endmodule
`default_nettype wire

FILE: src/counter_hash_position_seed.sv
// Top level: counter-hash seed position generator with pipeline control.
//
//  channel  | ports               | payload (low bit up)
//  ---------+---------------------+------------------------------------------
//  request  | req_t{valid,ready}  | batch_number[31:0], particle_index[62:32]
//  response | rsp_t{valid,ready}  | pos_x, pos_y, pos_z (COORD_WIDTH each)
//  csr      | csr_we/addr/wdata   | region low x,y,z then high x,y,z
//
// One item per cycle sustained while results are taken; the stages are the key
// stage, two five-stage finalizers (base, then per axis) and the four-stage placement.
// Reset clears all valid bits and the region registers.
// A stall squeezes out bubbles; req_tready drops only when every stage
// holds an item and the result is not taken.
`default_nettype none
module counter_hash_position_seed #(
   parameter int COORD_WIDTH = chp_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // batch_number[31:0], particle_index[62:32], bit [63] ignored
   input  wire logic [chp_pkg::REQ_DATA_W-1:0]         req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // pos_x, pos_y, pos_z, each COORD_WIDTH bits, zero pad to whole bytes
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   input  wire logic                                   csr_we,
   input  wire logic [chp_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  wire logic [COORD_WIDTH-1:0]                 csr_wdata
);

   localparam int CW     = COORD_WIDTH;
   localparam int RSP_W  = ((3*COORD_WIDTH+7)/8)*8;
   localparam int HW     = chp_pkg::HASH_W;
   localparam int MS     = chp_pkg::MIX_STAGES;
   localparam int PS     = chp_pkg::PLACE_STAGES;
   localparam int STAGES = 1 + 2*MS + PS;

   logic [STAGES-1:0] v_ff, v_in, en;

   logic [CW-1:0] low_x_ff, low_y_ff, low_z_ff;
   logic [CW-1:0] high_x_ff, high_y_ff, high_z_ff;

   logic [chp_pkg::BATCH_W-1:0]  batch;
   logic [chp_pkg::INDEX_W-1:0]  pidx;
   logic [chp_pkg::KEY_LO_W-1:0] key_lo;
   logic [HW-1:0]                key_in, key_ff;
   logic [HW-1:0]                base_h, hx, hy, hz;
   logic [CW-1:0]                pos_x, pos_y, pos_z;

   // Stage i advances when any stage from i to the output is empty or
   // the output transfer completes.
   always_comb begin
      for (int i = 0; i < STAGES; i++) begin
         en[i] = rsp_tready ||
                 ((v_ff | ((STAGES'(1) << i) - STAGES'(1))) != {STAGES{1'b1}});
      end
   end

   always_comb begin
      v_in = v_ff;
      for (int i = 0; i < STAGES; i++) begin
         if (en[i]) begin
            v_in[i] = (i == 0) ? req_tvalid : v_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Region registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_x_ff  <= '0;
         low_y_ff  <= '0;
         low_z_ff  <= '0;
         high_x_ff <= '0;
         high_y_ff <= '0;
         high_z_ff <= '0;
      end else if (csr_we) begin
         unique case (chp_pkg::cfg_index_type'(csr_addr))
            chp_pkg::CFG_LOW_X:  low_x_ff  <= csr_wdata;
            chp_pkg::CFG_LOW_Y:  low_y_ff  <= csr_wdata;
            chp_pkg::CFG_LOW_Z:  low_z_ff  <= csr_wdata;
            chp_pkg::CFG_HIGH_X: high_x_ff <= csr_wdata;
            chp_pkg::CFG_HIGH_Y: high_y_ff <= csr_wdata;
            chp_pkg::CFG_HIGH_Z: high_z_ff <= csr_wdata;
            default: begin
               // drop writes beyond the register map
            end
         endcase
      end
   end

   // Key: batch * 0x100000001b3 + index, mod 2^64
   assign batch  = req_tdata[chp_pkg::BATCH_W-1:0];
   assign pidx   = req_tdata[chp_pkg::BATCH_W +: chp_pkg::INDEX_W];
   assign key_lo = chp_pkg::KEY_LO_W'(batch) * chp_pkg::KEY_MUL_LO;
   assign key_in = {batch[HW-chp_pkg::KEY_MUL_SHIFT-1:0], {chp_pkg::KEY_MUL_SHIFT{1'b0}}}
                 + HW'(key_lo) + HW'(pidx);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         key_ff <= key_in;
      end
   end

   chp_mix u_mix_base (
      .clock    (clock),
      .en_i     (en[MS:1]),
      .z_i      (key_ff),
      .offset_i (chp_pkg::LANE_OFS_W'(0)),
      .h_o      (base_h)
   );

   chp_mix u_mix_x (
      .clock    (clock),
      .en_i     (en[2*MS:MS+1]),
      .z_i      (base_h),
      .offset_i (chp_pkg::LANE_OFS_W'(1)),
      .h_o      (hx)
   );

   chp_mix u_mix_y (
      .clock    (clock),
      .en_i     (en[2*MS:MS+1]),
      .z_i      (base_h),
      .offset_i (chp_pkg::LANE_OFS_W'(2)),
      .h_o      (hy)
   );

   chp_mix u_mix_z (
      .clock    (clock),
      .en_i     (en[2*MS:MS+1]),
      .z_i      (base_h),
      .offset_i (chp_pkg::LANE_OFS_W'(3)),
      .h_o      (hz)
   );

   chp_place #(.COORD_WIDTH(COORD_WIDTH)) u_place_x (
      .clock  (clock),
      .en_i   (en[STAGES-1:2*MS+1]),
      .low_i  (low_x_ff),
      .high_i (high_x_ff),
      .h_i    (hx),
      .pos_o  (pos_x)
   );

   chp_place #(.COORD_WIDTH(COORD_WIDTH)) u_place_y (
      .clock  (clock),
      .en_i   (en[STAGES-1:2*MS+1]),
      .low_i  (low_y_ff),
      .high_i (high_y_ff),
      .h_i    (hy),
      .pos_o  (pos_y)
   );

   chp_place #(.COORD_WIDTH(COORD_WIDTH)) u_place_z (
      .clock  (clock),
      .en_i   (en[STAGES-1:2*MS+1]),
      .low_i  (low_z_ff),
      .high_i (high_z_ff),
      .h_i    (hz),
      .pos_o  (pos_z)
   );

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[STAGES-1];
   assign rsp_tdata  = RSP_W'({pos_z, pos_y, pos_x});

   // Input is held off only when the whole pipe is full and stalled
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&v_ff))
      else $error("input stalled while the pipeline has a bubble");

   // Output drains once nothing is left upstream
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !(|v_ff[STAGES-2:0]) && !req_tvalid)
      |=> !rsp_tvalid)
      else $error("result repeated after the last transfer");

   // Reset leaves the pipeline empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (v_ff == '0))
      else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire
